### hdl/imts_pkg.sv
// Shared types and constants of the I2C master transfer sequencer.
`timescale 1ns / 1ps

package imts_pkg;

	// Default depth of the write byte buffer
	localparam int WRITE_BUFFER_DEPTH_DEFAULT = 32;

	// Command codes
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_BEGIN  = 2'd1,
		OP_STATUS = 2'd2,
		OP_ERROR  = 2'd3
	} op_t;

	// One command beat
	typedef struct packed {
		logic [1:0] operation;
		logic [6:0] target_address;
		logic [5:0] write_count;
		logic [7:0] read_count;
		logic [7:0] write_byte;
		logic       flag_start_sent;
		logic       flag_address_sent;
		logic       flag_rx_ready;
		logic       flag_tx_empty;
		logic       flag_byte_finished;
		logic [7:0] received_byte;
	} cmd_t;

	// One action beat
	typedef struct packed {
		logic       begin_accepted;
		logic       error_reported;
		logic       data_write_valid;
		logic [7:0] data_write_value;
		logic       ack_set;
		logic       ack_clear;
		logic       start_request;
		logic       stop_request;
		logic       read_data_valid;
		logic [7:0] read_data_value;
		logic       transfer_complete;
		logic       last_action;
	} act_t;

endpackage

### hdl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master write-then-read transfer sequencer.
`timescale 1ns / 1ps

// Usage
// The cmd channel takes load, begin, status and error beats; the act channel
// returns action beats (data register writes, ACK control, start/stop
// requests, received bytes, completion). last_action marks the final action
// beat of a command.
// A command beat is taken into a single work stage. Load and error commands
// retire from it without a wait, a begin once its action beat is given, and
// a status event once it has given every action beat it yields (one to
// four), or without a wait if it yields none. The next command is taken in
// the cycle the current one retires, so loads are taken at one command per
// cycle while nothing ahead of them stalls. Each action beat goes from the
// work stage into the output register. The write buffer is a one-port-write
// memory whose registered read port always points at the next byte to send,
// so each data write in an event finds its byte ready without a wait.
// Reset clears counters, busy and the latched error; buffer contents stay
// undefined and are not cleared. When act_ready is low the action beat
// waits in the output register, the work stage stalls, and cmd_ready
// drops once the work stage holds a command that still has beats to give.
module i2c_master_transfer_sequencer
	import imts_pkg::*;
#(
	parameter int WRITE_BUFFER_DEPTH = WRITE_BUFFER_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic act_valid,
	input  logic act_ready,
	output act_t act
);

	localparam int IDX_W  = $clog2(WRITE_BUFFER_DEPTH + 1);
	localparam int ADDR_W = $clog2(WRITE_BUFFER_DEPTH);

	// Status branch bits, in priority order
	localparam logic [3:0] BR_START = 4'b0001;
	localparam logic [3:0] BR_ADDR  = 4'b0010;
	localparam logic [3:0] BR_RX    = 4'b0100;
	localparam logic [3:0] BR_TX    = 4'b1000;

	// Work stage
	logic       valid_s1;
	cmd_t       item_s1;
	logic [3:0] mask_s1;

	// Sequencer state
	logic [IDX_W-1:0] load_index_q, load_index_d;
	logic [IDX_W-1:0] send_index_q, send_index_d;
	logic [6:0]       address_q, address_d;
	logic [IDX_W-1:0] writes_left_q, writes_left_d;
	logic [7:0]       reads_left_q, reads_left_d;
	logic             busy_q, busy_d;
	logic             error_q, error_d;

	// Output register
	logic act_valid_q;
	act_t act_q;

	// Buffer memory
	logic [7:0]        wbuf_mem [WRITE_BUFFER_DEPTH];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              mem_we;

	logic       emit_need, out_free, fire, done, cmd_take;
	logic [3:0] branch, mask_next, new_mask;
	logic [7:0] reads_dec;
	act_t       res;

	// Branch selection and handshake
	assign branch    = mask_s1 & (~mask_s1 + 4'd1);
	assign mask_next = mask_s1 & ~branch;
	assign out_free  = !act_valid_q || act_ready;
	assign emit_need = valid_s1 && ((op_t'(item_s1.operation) == OP_BEGIN) ||
		((op_t'(item_s1.operation) == OP_STATUS) && (mask_s1 != 4'd0)));
	assign fire      = emit_need && out_free;
	assign done      = valid_s1 && (!emit_need ||
		(fire && ((op_t'(item_s1.operation) == OP_BEGIN) || (mask_next == 4'd0))));
	assign cmd_ready = !valid_s1 || done;
	assign cmd_take  = cmd_valid && cmd_ready;
	assign reads_dec = reads_left_q - 8'd1;

	// Branches of a new status event, dropped when no transfer is running
	always_comb begin
		new_mask = {cmd.flag_tx_empty & ~cmd.flag_byte_finished, cmd.flag_rx_ready,
			cmd.flag_address_sent, cmd.flag_start_sent};
		if (!busy_d || (op_t'(cmd.operation) != OP_STATUS)) begin
			new_mask = 4'd0;
		end
	end

	// Command execution and action beat
	always_comb begin
		res           = '0;
		mem_we        = 1'b0;
		load_index_d  = load_index_q;
		send_index_d  = send_index_q;
		address_d     = address_q;
		writes_left_d = writes_left_q;
		reads_left_d  = reads_left_q;
		busy_d        = busy_q;
		error_d       = error_q;
		case (op_t'(item_s1.operation))
			OP_LOAD: begin
				if (valid_s1 && !busy_q && (load_index_q < IDX_W'(WRITE_BUFFER_DEPTH))) begin
					mem_we       = 1'b1;
					load_index_d = load_index_q + IDX_W'(1);
				end
			end
			OP_ERROR: begin
				if (valid_s1) begin
					error_d = 1'b1;
				end
			end
			OP_BEGIN: begin
				if (fire) begin
					res.last_action = 1'b1;
					if (!busy_q) begin
						address_d = item_s1.target_address;
						writes_left_d = (32'(item_s1.write_count) > 32'(WRITE_BUFFER_DEPTH)) ?
							IDX_W'(WRITE_BUFFER_DEPTH) : IDX_W'(item_s1.write_count);
						reads_left_d         = item_s1.read_count;
						send_index_d         = '0;
						load_index_d         = '0;
						res.begin_accepted   = 1'b1;
						res.error_reported   = error_q;
						res.start_request    = 1'b1;
						error_d              = 1'b0;
						busy_d               = 1'b1;
					end
				end
			end
			OP_STATUS: begin
				if (fire) begin
					res.last_action = (mask_next == 4'd0);
					case (branch)
						BR_START: begin
							res.data_write_valid = 1'b1;
							res.data_write_value = {address_q, (writes_left_q == '0)};
						end
						BR_ADDR: begin
							if (writes_left_q != '0) begin
								res.data_write_valid = 1'b1;
								res.data_write_value = rd_data_q;
								send_index_d         = send_index_q + IDX_W'(1);
								writes_left_d        = writes_left_q - IDX_W'(1);
							end else if (reads_left_q > 8'd1) begin
								res.ack_set = 1'b1;
							end else begin
								res.stop_request = 1'b1;
							end
						end
						BR_RX: begin
							res.read_data_valid = 1'b1;
							res.read_data_value = item_s1.received_byte;
							if (reads_left_q != 8'd0) begin
								reads_left_d = reads_dec;
								if (reads_dec == 8'd1) begin
									res.ack_clear    = 1'b1;
									res.stop_request = 1'b1;
								end
								if (reads_dec == 8'd0) begin
									res.transfer_complete = 1'b1;
									busy_d                = 1'b0;
								end
							end
						end
						BR_TX: begin
							if (writes_left_q != '0) begin
								res.data_write_valid = 1'b1;
								res.data_write_value = rd_data_q;
								send_index_d         = send_index_q + IDX_W'(1);
								writes_left_d        = writes_left_q - IDX_W'(1);
							end else if (reads_left_q != 8'd0) begin
								res.start_request = 1'b1;
							end else begin
								res.stop_request      = 1'b1;
								res.transfer_complete = 1'b1;
								busy_d                = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Buffer addresses: read port tracks the next send index
	assign wr_addr = load_index_q[ADDR_W-1:0];
	assign rd_addr = (send_index_d < IDX_W'(WRITE_BUFFER_DEPTH)) ?
		send_index_d[ADDR_W-1:0] : '0;

	// Write buffer memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			wbuf_mem[wr_addr] <= item_s1.write_byte;
		end
		rd_data_q <= wbuf_mem[rd_addr];
	end

	// Work stage payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			item_s1 <= cmd;
		end
	end

	// Control and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			mask_s1       <= 4'd0;
			load_index_q  <= '0;
			send_index_q  <= '0;
			address_q     <= '0;
			writes_left_q <= '0;
			reads_left_q  <= '0;
			busy_q        <= 1'b0;
			error_q       <= 1'b0;
			act_valid_q   <= 1'b0;
		end else begin
			if (cmd_take) begin
				valid_s1 <= 1'b1;
				mask_s1  <= new_mask;
			end else begin
				if (done) begin
					valid_s1 <= 1'b0;
				end
				if (fire) begin
					mask_s1 <= mask_next;
				end
			end
			load_index_q  <= load_index_d;
			send_index_q  <= send_index_d;
			address_q     <= address_d;
			writes_left_q <= writes_left_d;
			reads_left_q  <= reads_left_d;
			busy_q        <= busy_d;
			error_q       <= error_d;
			if (fire) begin
				act_valid_q <= 1'b1;
			end else if (act_ready) begin
				act_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (fire) begin
			act_q <= res;
		end
	end

	assign act_valid = act_valid_q;
	assign act       = act_q;

endmodule

### hdl/imts_checker.sv
// Port-level assertions for the I2C master transfer sequencer, with bind.
`timescale 1ns / 1ps

module imts_checker
	import imts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input cmd_t cmd,
	input logic act_valid,
	input logic act_ready,
	input act_t act
);

	// A stalled action beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && !act_ready |=> act_valid && $stable(act))
		else $error("action beat changed while stalled");

	// A begin reaches an idle output as a last beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && (cmd.operation == OP_BEGIN)) ##1 !act_valid
		|=> act_valid && act.last_action)
		else $error("begin answer missing");

	// A buffer load yields no action beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && (cmd.operation == OP_LOAD)) ##1 !act_valid
		|=> !act_valid)
		else $error("action beat after a load");

	// A reported error comes only with an accepted begin
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && act.error_reported
		|-> act.begin_accepted && act.start_request && act.last_action)
		else $error("error reported outside a begin answer");

endmodule

bind i2c_master_transfer_sequencer imts_checker u_imts_checker (.*);

### dv/tb_i2c_master_transfer_sequencer.sv
// Self-checking testbench of the I2C master transfer sequencer: directed table, random transfers.
`timescale 1ns / 1ps
module tb_i2c_master_transfer_sequencer;
	import imts_pkg::*;

	localparam int DEPTH = WRITE_BUFFER_DEPTH_DEFAULT;
	localparam int ITEM_TARGET = 310;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	// sender idle / receiver stall percentages per random phase
	localparam int IDLE_PCT [4] = '{0, 82, 0, 12};
	localparam int STALL_PCT [4] = '{0, 0, 82, 12};

	typedef struct {
		cmd_t c;
		int   reps;
		bit   typed;
		act_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic act_valid;
	logic act_ready = 1'b0;
	act_t act;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	// transfer state as the block should hold it
	logic [7:0] tx_bytes [DEPTH];
	int fill_idx = 0;
	int send_idx = 0;
	int written_hi = 0;
	logic [6:0] addr_q = '0;
	int writes_left = 0;
	int reads_left = 0;
	bit xfer_busy = 1'b0;
	bit err_pending = 1'b0;

	// action beats of the last command, and all beats still owed by the block
	act_t step_acts [4];
	int step_n = 0;
	act_t expected_acts [$];

	i2c_master_transfer_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.act_valid(act_valid),
		.act_ready(act_ready),
		.act(act)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void push_step(act_t a);
		step_acts[step_n] = a;
		step_n++;
	endfunction

	// data register write of the next buffered byte
	function automatic act_t next_write_beat();
		act_t a;
		a = '0;
		a.data_write_valid = 1'b1;
		a.data_write_value = (send_idx < DEPTH) ? tx_bytes[send_idx] : 8'h00;
		send_idx++;
		writes_left--;
		return a;
	endfunction

	function automatic void predict_actions(cmd_t c);
		act_t a;
		step_n = 0;
		case (c.operation)
			OP_LOAD: begin
				if (!xfer_busy && fill_idx < DEPTH) begin
					tx_bytes[fill_idx] = c.write_byte;
					fill_idx++;
					if (fill_idx > written_hi)
						written_hi = fill_idx;
				end
			end
			OP_ERROR: err_pending = 1'b1;
			OP_BEGIN: begin
				a = '0;
				if (!xfer_busy) begin
					addr_q = c.target_address;
					writes_left = (c.write_count > DEPTH) ? DEPTH : int'(c.write_count);
					reads_left = c.read_count;
					send_idx = 0;
					fill_idx = 0;
					a.begin_accepted = 1'b1;
					a.error_reported = err_pending;
					a.start_request = 1'b1;
					err_pending = 1'b0;
					xfer_busy = 1'b1;
				end
				push_step(a);
			end
			OP_STATUS: begin
				if (xfer_busy) begin
					// address byte, read bit set when there is nothing to write
					if (c.flag_start_sent) begin
						a = '0;
						a.data_write_valid = 1'b1;
						a.data_write_value = {addr_q, (writes_left == 0) ? 1'b1 : 1'b0};
						push_step(a);
					end
					if (c.flag_address_sent) begin
						if (writes_left != 0) begin
							a = next_write_beat();
						end else begin
							a = '0;
							if (reads_left > 1)
								a.ack_set = 1'b1;
							else
								a.stop_request = 1'b1;
						end
						push_step(a);
					end
					// byte always delivered; counter only moves while reads remain
					if (c.flag_rx_ready) begin
						a = '0;
						a.read_data_valid = 1'b1;
						a.read_data_value = c.received_byte;
						if (reads_left > 0) begin
							reads_left--;
							if (reads_left == 1) begin
								a.ack_clear = 1'b1;
								a.stop_request = 1'b1;
							end
							if (reads_left == 0) begin
								a.transfer_complete = 1'b1;
								xfer_busy = 1'b0;
							end
						end
						push_step(a);
					end
					// transmit empty is masked by byte finished
					if (c.flag_tx_empty && !c.flag_byte_finished) begin
						if (writes_left != 0) begin
							a = next_write_beat();
						end else begin
							a = '0;
							if (reads_left != 0) begin
								a.start_request = 1'b1;
							end else begin
								a.stop_request = 1'b1;
								a.transfer_complete = 1'b1;
								xfer_busy = 1'b0;
							end
						end
						push_step(a);
					end
				end
			end
			default: begin
			end
		endcase
		if (step_n > 0)
			step_acts[step_n - 1].last_action = 1'b1;
	endfunction

	// ---------------------------------------------------------------- command builders

	function automatic cmd_t rand_cmd();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(cmd_t) - 1:0];
	endfunction

	// keep a begin from sending buffer entries that were never loaded
	function automatic logic [5:0] fit_wc(logic [5:0] wc);
		int n;
		n = (wc > DEPTH) ? DEPTH : int'(wc);
		return (n > written_hi) ? 6'(written_hi) : wc;
	endfunction

	function automatic cmd_t mk_load(logic [7:0] b);
		cmd_t c;
		c = rand_cmd();
		c.operation = OP_LOAD;
		c.write_byte = b;
		return c;
	endfunction

	function automatic cmd_t mk_error();
		cmd_t c;
		c = rand_cmd();
		c.operation = OP_ERROR;
		return c;
	endfunction

	function automatic cmd_t mk_begin(logic [6:0] addr, logic [5:0] wc, logic [7:0] rc);
		cmd_t c;
		c = rand_cmd();
		c.operation = OP_BEGIN;
		c.target_address = addr;
		c.write_count = wc;
		c.read_count = rc;
		return c;
	endfunction

	function automatic cmd_t mk_status(bit sb, bit ad, bit rx, bit txe, bit btf,
			logic [7:0] rb);
		cmd_t c;
		c = rand_cmd();
		c.operation = OP_STATUS;
		c.flag_start_sent = sb;
		c.flag_address_sent = ad;
		c.flag_rx_ready = rx;
		c.flag_tx_empty = txe;
		c.flag_byte_finished = btf;
		c.received_byte = rb;
		return c;
	endfunction

	// single-beat answer, always the last beat of its command
	function automatic act_t exp_beat(bit acc, bit err, bit dwv, logic [7:0] dwd, bit acks,
			bit start, bit stop, bit done);
		act_t a;
		a = '0;
		a.begin_accepted = acc;
		a.error_reported = err;
		a.data_write_valid = dwv;
		a.data_write_value = dwd;
		a.ack_set = acks;
		a.start_request = start;
		a.stop_request = stop;
		a.transfer_complete = done;
		a.last_action = 1'b1;
		return a;
	endfunction

	function automatic dir_row_t drow(cmd_t c, int reps, bit typed, act_t want);
		dir_row_t r;
		r.c = c;
		r.reps = reps;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// present one command beat at the falling edge, hold until taken
	task automatic send_cmd(cmd_t c, bit typed = 1'b0, act_t want = '0);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd = c;
		cmd_valid = 1'b1;
		do @(posedge clk); while (cmd_ready !== 1'b1);
		items_sent++;
		predict_actions(c);
		if (typed)
			expected_acts.push_back(want);
		else
			for (int i = 0; i < step_n; i++)
				expected_acts.push_back(step_acts[i]);
	endtask

	task automatic send_noise();
		cmd_t c;
		c = rand_cmd();
		if (c.operation == OP_BEGIN)
			c.write_count = fit_wc(c.write_count);
		send_cmd(c);
	endtask

	// load, begin, then mostly a plausible bus sequence with some disorder mixed in
	task automatic run_transfer();
		int n_load;
		int wc;
		int rc;
		int guard;
		bit restarted;
		cmd_t c;
		n_load = ($urandom_range(7) == 0) ? $urandom_range(34, 28) : $urandom_range(6);
		for (int i = 0; i < n_load; i++)
			send_cmd(mk_load(8'($urandom)));
		wc = ($urandom_range(5) == 0) ? $urandom_range(63) : n_load;
		rc = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(5);
		send_cmd(mk_begin(7'($urandom), fit_wc(6'(wc)), 8'(rc)));
		restarted = (wc == 0);
		send_cmd(mk_status(1, 0, 0, 0, 0, 8'($urandom)));
		send_cmd(mk_status(0, 1, 0, 0, 0, 8'($urandom)));
		guard = 0;
		while (xfer_busy && guard < 90) begin
			guard++;
			case ($urandom_range(11))
				0: begin
					c = rand_cmd();
					c.operation = OP_STATUS;
					send_cmd(c);
				end
				1: send_cmd(mk_error());
				2: send_cmd(mk_begin(7'($urandom), fit_wc(6'($urandom)), 8'($urandom)));
				3: send_cmd(mk_load(8'($urandom)));
				default: begin
					if (writes_left != 0 || reads_left == 0) begin
						send_cmd(mk_status(0, 0, 0, 1, 0, 8'($urandom)));
					end else if (!restarted) begin
						// repeated start into the read phase
						send_cmd(mk_status(0, 0, 0, 1, 0, 8'($urandom)));
						send_cmd(mk_status(1, 0, 0, 0, 0, 8'($urandom)));
						send_cmd(mk_status(0, 1, 0, 0, 0, 8'($urandom)));
						restarted = 1'b1;
					end else begin
						send_cmd(mk_status(0, 0, 1, 0, 0, 8'($urandom)));
					end
				end
			endcase
		end
	endtask

	always @(negedge clk) begin
		act_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string msg, act_t got, act_t want);
		$display("ERROR @%0t: %s got=%h want=%h", $time, msg, got, want);
		fail_count++;
	endtask

	task automatic check_beat(act_t got);
		act_t want;
		string bad;
		if (expected_acts.size() == 0) begin
			report_mismatch("action beat with nothing expected", got, '0);
			return;
		end
		want = expected_acts.pop_front();
		bad = "";
		if (got.begin_accepted !== want.begin_accepted) bad = {bad, " begin_accepted"};
		if (got.error_reported !== want.error_reported) bad = {bad, " error_reported"};
		if (got.data_write_valid !== want.data_write_valid) bad = {bad, " data_write_valid"};
		if (got.data_write_value !== want.data_write_value) bad = {bad, " data_write_value"};
		if (got.ack_set !== want.ack_set) bad = {bad, " ack_set"};
		if (got.ack_clear !== want.ack_clear) bad = {bad, " ack_clear"};
		if (got.start_request !== want.start_request) bad = {bad, " start_request"};
		if (got.stop_request !== want.stop_request) bad = {bad, " stop_request"};
		if (got.read_data_valid !== want.read_data_valid) bad = {bad, " read_data_valid"};
		if (got.read_data_value !== want.read_data_value) bad = {bad, " read_data_value"};
		if (got.transfer_complete !== want.transfer_complete) bad = {bad, " transfer_complete"};
		if (got.last_action !== want.last_action) bad = {bad, " last_action"};
		if (bad != "")
			report_mismatch({"action beat field mismatch:", bad}, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && act_valid && act_ready)
			check_beat(act);
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (act_valid && act_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_i2c_master_transfer_sequencer: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		dir_row_t rows [$];
		int limit;
		cmd_t c;

		// idle, first transfer with nothing to write or read, refused begin
		rows.push_back(drow(mk_status(1, 1, 1, 1, 1, 8'hFF), 1, 0, '0));
		rows.push_back(drow(mk_begin(7'h00, 6'd0, 8'd0), 1, 1,
			exp_beat(1, 0, 0, 8'h00, 0, 1, 0, 0)));
		rows.push_back(drow(mk_begin(7'h7F, 6'd63, 8'd255), 1, 1,
			exp_beat(0, 0, 0, 8'h00, 0, 0, 0, 0)));
		rows.push_back(drow(mk_load(8'hFF), 1, 0, '0));
		rows.push_back(drow(mk_error(), 1, 0, '0));
		rows.push_back(drow(mk_status(1, 0, 0, 0, 0, 8'h00), 1, 1,
			exp_beat(0, 0, 1, 8'h01, 0, 0, 0, 0)));
		rows.push_back(drow(mk_status(0, 1, 0, 0, 0, 8'h00), 1, 1,
			exp_beat(0, 0, 0, 8'h00, 0, 0, 1, 0)));
		rows.push_back(drow(mk_status(0, 0, 0, 1, 1, 8'h00), 1, 0, '0));
		rows.push_back(drow(mk_status(0, 0, 0, 1, 0, 8'h00), 1, 1,
			exp_beat(0, 0, 0, 8'h00, 0, 0, 1, 1)));
		// fill the buffer and one more; clamped write count; latched error reported
		rows.push_back(drow(mk_load(8'hE0), 33, 0, '0));
		rows.push_back(drow(mk_begin(7'h7F, 6'd63, 8'd2), 1, 1,
			exp_beat(1, 1, 0, 8'h00, 0, 1, 0, 0)));
		rows.push_back(drow(mk_status(1, 1, 1, 1, 1, 8'hFF), 1, 0, '0));
		rows.push_back(drow(mk_status(1, 1, 1, 1, 0, 8'h00), 1, 0, '0));
		rows.push_back(drow(mk_status(0, 0, 1, 0, 0, 8'h33), 1, 0, '0));
		// write-only transfer
		rows.push_back(drow(mk_load(8'h5A), 3, 0, '0));
		rows.push_back(drow(mk_begin(7'h55, 6'd3, 8'd0), 1, 1,
			exp_beat(1, 0, 0, 8'h00, 0, 1, 0, 0)));
		rows.push_back(drow(mk_status(0, 0, 0, 1, 0, 8'h00), 4, 0, '0));
		// read-only transfer
		rows.push_back(drow(mk_begin(7'h2A, 6'd0, 8'd3), 1, 1,
			exp_beat(1, 0, 0, 8'h00, 0, 1, 0, 0)));
		rows.push_back(drow(mk_status(0, 1, 0, 0, 0, 8'h00), 1, 1,
			exp_beat(0, 0, 0, 8'h00, 1, 0, 0, 0)));
		rows.push_back(drow(mk_status(0, 0, 1, 0, 0, 8'hA0), 3, 0, '0));
		// write then repeated start then single read
		rows.push_back(drow(mk_begin(7'h11, 6'd1, 8'd1), 1, 1,
			exp_beat(1, 0, 0, 8'h00, 0, 1, 0, 0)));
		rows.push_back(drow(mk_status(0, 0, 0, 1, 0, 8'h00), 2, 0, '0));
		rows.push_back(drow(mk_status(1, 0, 0, 0, 0, 8'h00), 1, 1,
			exp_beat(0, 0, 1, 8'h23, 0, 0, 0, 0)));
		rows.push_back(drow(mk_status(0, 1, 0, 0, 0, 8'h00), 1, 1,
			exp_beat(0, 0, 0, 8'h00, 0, 0, 1, 0)));
		rows.push_back(drow(mk_status(0, 0, 1, 0, 0, 8'h7E), 1, 0, '0));
		// receive with nothing left to read
		rows.push_back(drow(mk_begin(7'h7F, 6'd2, 8'd0), 1, 1,
			exp_beat(1, 0, 0, 8'h00, 0, 1, 0, 0)));
		rows.push_back(drow(mk_status(0, 0, 1, 0, 0, 8'hC3), 1, 0, '0));
		rows.push_back(drow(mk_status(0, 0, 0, 1, 0, 8'h00), 3, 0, '0));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[r]) begin
			for (int i = 0; i < rows[r].reps; i++) begin
				c = rows[r].c;
				if (c.operation == OP_LOAD)
					c.write_byte += 8'(i);
				if (c.operation == OP_STATUS)
					c.received_byte += 8'(i);
				send_cmd(c, rows[r].typed, rows[r].want);
			end
		end

		// random part, one handshake pressure setting per phase
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = IDLE_PCT[ph];
			recv_stall_pct = STALL_PCT[ph];
			limit = items_sent + (ITEM_TARGET - items_sent) / (4 - ph);
			while (items_sent < limit) begin
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(3, 1)) send_noise();
				else
					run_transfer();
			end
		end

		@(negedge clk);
		cmd_valid = 1'b0;
		while (expected_acts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_i2c_master_transfer_sequencer: PASS");
		else
			$display("tb_i2c_master_transfer_sequencer: FAIL");
		$finish;
	end

endmodule

### filelist.f
hdl/imts_pkg.sv
hdl/i2c_master_transfer_sequencer.sv
hdl/imts_checker.sv
dv/tb_i2c_master_transfer_sequencer.sv
